// File: sv/pfa_pkg.sv
// Package for the page frame allocator: payload structs, command and operation codes,
// back-end state encoding and fixed field widths.
// Depends on nothing; every other file of the block imports it.
package pfa_pkg;

  localparam int unsigned PAGE_W          = 10;
  localparam int unsigned FRAME_NUM_W     = 10;
  localparam int unsigned FLAGS_W         = 8;
  localparam int unsigned ENTRY_W         = FRAME_NUM_W + FLAGS_W;
  localparam int unsigned DIR_SEL_W       = 2;
  localparam int unsigned DIR_SEL_RANGE   = 1 << DIR_SEL_W;
  localparam int unsigned ENTRIES_PER_DIR = 1 << PAGE_W;
  localparam int unsigned BYTES_W         = 32;
  // Largest frame count a check can ask for is 2^20 (4 KB frames), so 21 bits.
  localparam int unsigned NEED_W          = 21;
  localparam int unsigned GIVEN_W         = 5;
  localparam int unsigned FREE_OUT_W      = 6;
  localparam int unsigned PRESENT_FLAG_IDX = 0;
  // Present, writable, user and 4 MB page.
  localparam logic [FLAGS_W-1:0] ALLOC_FLAGS = 8'h87;

  typedef enum logic [1:0] {
    CMD_CHECK = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_MAP   = 2'd3
  } pfa_command_t;

  // Classified operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CHECK,
    OP_ALLOC,
    OP_FREE,
    OP_MAP
  } pfa_op_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } pfa_back_state_t;

  typedef struct packed {
    logic [1:0]             command;
    logic [DIR_SEL_W-1:0]   directory_select;
    logic [PAGE_W-1:0]      virtual_page;
    logic [BYTES_W-1:0]     request_bytes;
    logic [FRAME_NUM_W-1:0] map_frame;
    logic [FLAGS_W-1:0]     map_flags;
  } pfa_request_t;

  typedef struct packed {
    logic                  success;
    logic [GIVEN_W-1:0]    frame_given;
    logic [FREE_OUT_W-1:0] frames_free;
    logic                  flush_request;
    logic [PAGE_W-1:0]     flush_page;
  } pfa_result_t;

  typedef struct packed {
    pfa_op_t              op;
    logic [DIR_SEL_W-1:0] dir;
    logic [PAGE_W-1:0]    page;
    logic [NEED_W-1:0]    need;
    logic [ENTRY_W-1:0]   entry;
  } pfa_item_t;

endpackage

// File: sv/pfa_front.sv
// Front end of the page frame allocator: decodes a command item into an operation,
// rounds the check size up to whole frames and builds the map entry.
// Depends on pfa_pkg.
module pfa_front
  import pfa_pkg::*;
#(
  parameter int unsigned DIRECTORIES = 4,
  parameter int unsigned FRAME_SHIFT = 22
) (
  input  pfa_request_t request,
  output pfa_item_t    item
);

  logic [BYTES_W:0] round_sum;
  logic             dir_ok;

  assign round_sum = {1'b0, request.request_bytes}
                   + (((BYTES_W + 1)'(1) << FRAME_SHIFT) - (BYTES_W + 1)'(1));
  assign dir_ok    = 32'(request.directory_select) < DIRECTORIES;

  always_comb begin
    item.dir   = request.directory_select;
    item.page  = request.virtual_page;
    item.need  = NEED_W'(round_sum >> FRAME_SHIFT);
    item.entry = {request.map_frame, request.map_flags};
    unique case (request.command)
      CMD_CHECK: item.op = OP_CHECK;
      CMD_ALLOC: item.op = dir_ok ? OP_ALLOC : OP_NOP;
      CMD_FREE:  item.op = dir_ok ? OP_FREE : OP_NOP;
      CMD_MAP:   item.op = dir_ok ? OP_MAP : OP_NOP;
      default:   item.op = OP_NOP;
    endcase
  end

endmodule

// File: sv/pfa_queue.sv
// Two-entry queue that decouples the allocator front end from the back end.
// Depends on pfa_pkg.
module pfa_queue
  import pfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pfa_item_t push_item,
  input  logic      pop,
  output pfa_item_t head_item,
  output logic      empty,
  output logic      full
);

  localparam int unsigned DEPTH  = 2;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = PTR_W + 1;

  pfa_item_t         slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign empty     = (fill == '0);
  assign full      = (fill == FILL_W'(DEPTH));
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue popped while empty");
`endif

endmodule

// File: sv/pfa_back.sv
// Back end of the page frame allocator: owns the frame bitmap, the free count and the
// directory memory, and executes queued operations one at a time, each through IDLE and EXEC.
// Depends on pfa_pkg.
module pfa_back
  import pfa_pkg::*;
#(
  parameter int unsigned FRAMES      = 32,
  parameter int unsigned DIRECTORIES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  pfa_item_t   head_item,
  output logic        pop,
  output logic        clearing,
  output logic        done,
  output pfa_result_t result
);

  // Only directories reachable through the select field need storage.
  localparam int unsigned DIRS_USED = (DIRECTORIES < DIR_SEL_RANGE) ? DIRECTORIES
                                                                    : DIR_SEL_RANGE;
  localparam int unsigned DEPTH     = DIRS_USED * ENTRIES_PER_DIR;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned FW        = $clog2(FRAMES);
  localparam int unsigned CW        = $clog2(FRAMES + 1);

  pfa_back_state_t        state;
  pfa_back_state_t        state_next;
  pfa_item_t              work;
  logic [ENTRY_W-1:0]     dir_mem [DEPTH];
  logic [ENTRY_W-1:0]     rd_entry;
  logic [ADDR_W-1:0]      clear_addr;
  logic                   clear_last;
  logic [FRAMES-1:0]      frame_used;
  logic [FRAMES-1:0]      frame_used_next;
  logic [CW-1:0]          free_count;
  logic [CW-1:0]          free_count_next;
  logic                   free_found;
  logic [FW-1:0]          free_idx;
  logic [FRAME_NUM_W-1:0] old_frame;
  logic                   old_in_range;
  logic [FW-1:0]          old_idx;
  logic                   mem_re;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [ENTRY_W-1:0]     mem_wdata;
  logic [ADDR_W-1:0]      head_addr;
  logic [ADDR_W-1:0]      work_addr;
  logic                   exec_we;
  logic [ENTRY_W-1:0]     exec_wdata;
  pfa_result_t            res_next;

  assign head_addr  = ADDR_W'({head_item.dir, head_item.page});
  assign work_addr  = ADDR_W'({work.dir, work.page});
  assign clear_last = (clear_addr == ADDR_W'(DEPTH - 1));

  // Lowest free frame.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (!frame_used[i]) begin
        free_found = 1'b1;
        free_idx   = FW'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: state_next = clear_last ? BK_IDLE : BK_CLEAR;
      BK_IDLE:  state_next = empty ? BK_IDLE : BK_EXEC;
      BK_EXEC:  state_next = BK_IDLE;
      default:  state_next = BK_CLEAR;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = work_addr;
    mem_wdata = exec_wdata;
    clearing  = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        clearing  = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clear_addr;
        mem_wdata = '0;
      end
      BK_IDLE: begin
        pop    = !empty;
        mem_re = !empty;
      end
      BK_EXEC: mem_we = exec_we;
      default: ;
    endcase
  end

  // Execution of the current operation, using the entry read in the previous cycle.
  always_comb begin
    frame_used_next = frame_used;
    free_count_next = free_count;
    exec_we         = 1'b0;
    exec_wdata      = '0;
    res_next        = '0;
    old_frame       = rd_entry[ENTRY_W-1:FLAGS_W];
    old_in_range    = 32'(old_frame) < FRAMES;
    old_idx         = FW'(old_frame);
    case (work.op)
      OP_CHECK: begin
        res_next.success = (free_count != '0) && (NEED_W'(free_count) >= work.need);
      end
      OP_ALLOC: begin
        if (free_found) begin
          frame_used_next[free_idx] = 1'b1;
          if (free_count != '0) free_count_next = free_count - CW'(1);
          exec_we                = 1'b1;
          exec_wdata             = {FRAME_NUM_W'(free_idx), ALLOC_FLAGS};
          res_next.success       = 1'b1;
          res_next.frame_given   = GIVEN_W'(free_idx);
          res_next.flush_request = 1'b1;
        end
      end
      OP_FREE: begin
        if (rd_entry[PRESENT_FLAG_IDX]) begin
          if (old_in_range && frame_used[old_idx]) begin
            frame_used_next[old_idx] = 1'b0;
            if (free_count < CW'(FRAMES)) free_count_next = free_count + CW'(1);
          end
          exec_we                = 1'b1;
          exec_wdata             = '0;
          res_next.success       = 1'b1;
          res_next.flush_request = 1'b1;
        end
      end
      OP_MAP: begin
        exec_we                = 1'b1;
        exec_wdata             = work.entry;
        res_next.success       = 1'b1;
        res_next.flush_request = 1'b1;
      end
      default: ;
    endcase
    res_next.frames_free = FREE_OUT_W'(free_count_next);
    res_next.flush_page  = res_next.flush_request ? work.page : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_CLEAR;
      clear_addr <= '0;
      frame_used <= '0;
      free_count <= CW'(FRAMES);
      done       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) clear_addr <= clear_addr + ADDR_W'(1);
      if (state == BK_EXEC) begin
        frame_used <= frame_used_next;
        free_count <= free_count_next;
      end
      done <= (state == BK_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) work <= head_item;
    if (state == BK_EXEC) result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) dir_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_entry <= dir_mem[head_addr];
  end

`ifndef SYNTHESIS
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == BK_EXEC))
    else $error("result strobe without an executed operation");
  a_count_matches_map: assert property (@(posedge clk) disable iff (rst)
    (32'($countones(frame_used)) + 32'(free_count)) == FRAMES)
    else $error("free count disagrees with the frame bitmap");
`endif

endmodule

// File: sv/page_frame_allocator_with_directory.sv
// Top level of the page frame allocator with page directories.
// Depends on pfa_pkg, pfa_front, pfa_queue and pfa_back.
//
// Usage:
//   An item is taken on the request port at a rising edge where start is high and
//   busy is low. Commands are check capacity, allocate and map, free mapping and
//   write entry directly. Every item gives exactly one result on the result port,
//   shown for a single cycle with done high; the receiver cannot hold it off.
// Operation:
//   An accepted item is written into the queue. In its idle state the back end pops
//   the head item and reads its directory entry from the synchronous memory; in its
//   execute state it writes the entry back, updates bitmap and count and registers
//   the result with done. Items are executed one at a time. Two items can wait in
//   the queue between front end and back end; busy is high while the queue is full.
// Reset:
//   Reset empties the queue, marks every frame free and sets the free count to
//   FRAMES. The directory memory, min(DIRECTORIES, 4) * 1024 entries (4096 by
//   default), is then cleared one entry per cycle; busy is high throughout.
module page_frame_allocator_with_directory
  import pfa_pkg::*;
#(
  parameter int unsigned FRAMES      = 32,
  parameter int unsigned DIRECTORIES = 4,
  parameter int unsigned FRAME_SHIFT = 22
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  pfa_request_t request,
  output logic         busy,
  output logic         done,
  output pfa_result_t  result
);

  pfa_item_t front_item;
  pfa_item_t head_item;
  logic      push;
  logic      pop;
  logic      empty;
  logic      full;
  logic      clearing;

  // Nothing is taken while the directory is being cleared or the queue is full.
  assign busy = clearing || full;
  assign push = start && !busy;

  pfa_front #(
    .DIRECTORIES(DIRECTORIES),
    .FRAME_SHIFT(FRAME_SHIFT)
  ) u_front (
    .request(request),
    .item   (front_item)
  );

  pfa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(front_item),
    .pop      (pop),
    .head_item(head_item),
    .empty    (empty),
    .full     (full)
  );

  pfa_back #(
    .FRAMES     (FRAMES),
    .DIRECTORIES(DIRECTORIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head_item(head_item),
    .pop      (pop),
    .clearing (clearing),
    .done     (done),
    .result   (result)
  );

endmodule
